>>> rtl/core/tief_pkg.sv
// ----------------------------------------------------------------------------
// tief_pkg
// Types and constants shared by the telnet filter / line editor modules.
// ----------------------------------------------------------------------------
package tief_pkg;

    // Edit operation codes as seen on the edit_op port
    localparam logic [2:0] EDIT_NONE    = 3'd0;
    localparam logic [2:0] EDIT_APPEND  = 3'd1;
    localparam logic [2:0] EDIT_DELETE  = 3'd2;
    localparam logic [2:0] EDIT_COMMIT  = 3'd3;
    localparam logic [2:0] EDIT_ABANDON = 3'd4;

    // Telnet command bytes
    localparam logic [7:0] TN_IAC = 8'd255;
    localparam logic [7:0] TN_SB  = 8'd250;
    localparam logic [7:0] TN_WILL = 8'd251;
    localparam logic [7:0] TN_DONT = 8'd254;
    localparam logic [7:0] TN_SE  = 8'd240;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_CARET = 8'h5e;
    localparam logic [7:0] CH_DEL   = 8'h7f;

    // Editing action handed from the front end to the back end
    typedef enum logic [2:0] {
        ACT_APPEND,
        ACT_DELETE,
        ACT_DELETE_QUIET,
        ACT_COMMIT,
        ACT_ABANDON
    } act_kind_t;

    typedef struct packed {
        act_kind_t   kind;
        logic [7:0]  ch;     // appended character
        logic        mask;   // echo '*' instead of the character
        logic [8:0]  len;    // reported line length
    } action_t;

    // Index of the final result for each action
    function automatic logic [1:0] last_step(input act_kind_t kind);
        logic [1:0] s;
        s = 2'd0;
        case (kind)
            ACT_APPEND:       s = 2'd0;
            ACT_DELETE_QUIET: s = 2'd0;
            ACT_DELETE:       s = 2'd2;
            ACT_COMMIT:       s = 2'd1;
            ACT_ABANDON:      s = 2'd3;
            default:          s = 2'd0;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/core/tief_front.sv
// ----------------------------------------------------------------------------
// tief_front
// Telnet command stripper and line length tracker; emits editing actions.
// ----------------------------------------------------------------------------
module tief_front
    import tief_pkg::*;
#(
    parameter int LINE_LIMIT = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       last_of_packet,
    input  logic       password_mode,
    input  logic       discard,
    output logic       push,
    output action_t    push_data
);

    localparam int LEN_W = $clog2(LINE_LIMIT + 2);

    typedef enum logic [1:0] {
        CMD_NORMAL,
        CMD_AFTER_IAC,
        CMD_OPTION,
        CMD_SUBNEG
    } cmd_state_t;

    cmd_state_t       cmd_state_reg, cmd_state_next;
    logic             skip_reg, skip_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] len_report;
    logic [31:0]      len_wide;

    // Low nine bits of the reported length
    assign len_wide = 32'(len_report);

    always_comb
    begin
        cmd_state_next = cmd_state_reg;
        skip_next      = skip_reg;
        len_next       = len_reg;
        len_report     = len_reg;
        push           = 1'b0;
        push_data.kind = ACT_APPEND;
        push_data.ch   = data_byte;
        push_data.mask = password_mode;
        push_data.len  = len_wide[8:0];

        if (accept && !discard)
        begin
            skip_next = 1'b0;
            if (skip_reg && (data_byte == CH_LF || data_byte == CH_NUL))
            begin
                // LF or NUL right after CR: dropped
            end
            else
            begin
                case (cmd_state_reg)
                    CMD_AFTER_IAC:
                    begin
                        if (data_byte == TN_SB)
                            cmd_state_next = CMD_SUBNEG;
                        else if (data_byte >= TN_WILL && data_byte <= TN_DONT)
                            cmd_state_next = CMD_OPTION;
                        else
                            cmd_state_next = CMD_NORMAL;
                    end
                    CMD_OPTION:
                        cmd_state_next = CMD_NORMAL;
                    CMD_SUBNEG:
                    begin
                        if (data_byte == TN_SE)
                            cmd_state_next = CMD_NORMAL;
                    end
                    default:
                    begin
                        if (data_byte == TN_IAC)
                        begin
                            cmd_state_next = CMD_AFTER_IAC;
                        end
                        else if (data_byte == CH_CR || data_byte == CH_LF)
                        begin
                            skip_next      = (data_byte == CH_CR) && !last_of_packet;
                            len_next       = '0;
                            push           = 1'b1;
                            push_data.kind = ACT_COMMIT;
                        end
                        else if (data_byte == CH_DEL || data_byte == CH_BS)
                        begin
                            if (len_reg != '0)
                            begin
                                len_next       = len_reg - 1'b1;
                                len_report     = len_reg - 1'b1;
                                push           = 1'b1;
                                push_data.kind = password_mode ? ACT_DELETE_QUIET
                                                               : ACT_DELETE;
                            end
                        end
                        else if (data_byte == CH_ETX)
                        begin
                            len_next       = '0;
                            len_report     = '0;
                            push           = 1'b1;
                            push_data.kind = ACT_ABANDON;
                        end
                        else if (data_byte >= CH_SP && len_reg <= LEN_W'(LINE_LIMIT))
                        begin
                            len_next       = len_reg + 1'b1;
                            len_report     = len_reg + 1'b1;
                            push           = 1'b1;
                            push_data.kind = ACT_APPEND;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_state_reg <= CMD_NORMAL;
            skip_reg      <= 1'b0;
            len_reg       <= '0;
        end
        else
        begin
            cmd_state_reg <= cmd_state_next;
            skip_reg      <= skip_next;
            len_reg       <= len_next;
        end
    end

    // Line never grows past one over the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(LINE_LIMIT + 1))
        else $error("tief_front: pending length over limit");

    // Edits only come from normal data
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cmd_state_reg == CMD_NORMAL && !discard))
        else $error("tief_front: action from command or discarded byte");

endmodule

>>> rtl/core/tief_queue.sv
// ----------------------------------------------------------------------------
// tief_queue
// Small register FIFO of editing actions between front and back end.
// ----------------------------------------------------------------------------
module tief_queue
    import tief_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  action_t push_data,
    input  logic    pop,
    output action_t head,
    output logic    empty,
    output logic    full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    action_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("tief_queue: write into full queue");

    assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("tief_queue: read from empty queue");

endmodule

>>> rtl/core/tief_back.sv
// ----------------------------------------------------------------------------
// tief_back
// Expands each editing action into its echo transactions, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module tief_back
    import tief_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  action_t    head,
    input  logic       empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       echo_valid,
    output logic [7:0] echo_byte,
    output logic [2:0] edit_op,
    output logic [7:0] edit_char,
    output logic [8:0] line_length,
    output logic       last
);

    logic [1:0] step_reg;
    logic       out_valid_reg;
    logic       echo_valid_reg;
    logic [7:0] echo_byte_reg;
    logic [2:0] edit_op_reg;
    logic [7:0] edit_char_reg;
    logic [8:0] line_length_reg;
    logic       last_reg;

    logic       load;
    logic       is_last;
    logic       r_echo_valid;
    logic [7:0] r_echo_byte;
    logic [2:0] r_op;

    assign load    = !empty && (!out_valid_reg || out_ready);
    assign is_last = (step_reg == last_step(head.kind));
    assign pop     = load && is_last;

    always_comb
    begin
        r_echo_valid = 1'b1;
        r_echo_byte  = CH_NUL;
        r_op         = EDIT_NONE;
        case (head.kind)
            ACT_APPEND:
            begin
                r_echo_byte = head.mask ? CH_STAR : head.ch;
                r_op        = EDIT_APPEND;
            end
            ACT_DELETE_QUIET:
            begin
                r_echo_valid = 1'b0;
                r_op         = EDIT_DELETE;
            end
            ACT_DELETE:
            begin
                r_echo_byte = (step_reg == 2'd1) ? CH_SP : CH_BS;
                r_op        = EDIT_DELETE;
            end
            ACT_COMMIT:
            begin
                r_echo_byte = (step_reg == 2'd0) ? CH_CR : CH_LF;
                r_op        = EDIT_COMMIT;
            end
            ACT_ABANDON:
            begin
                case (step_reg)
                    2'd0:    r_echo_byte = CH_CARET;
                    2'd1:    r_echo_byte = CH_C;
                    2'd2:    r_echo_byte = CH_CR;
                    default: r_echo_byte = CH_LF;
                endcase
                r_op = EDIT_ABANDON;
            end
            default:
            begin
                r_echo_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                step_reg <= is_last ? 2'd0 : step_reg + 2'd1;
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            echo_valid_reg  <= r_echo_valid;
            echo_byte_reg   <= r_echo_byte;
            edit_op_reg     <= (step_reg == 2'd0) ? r_op : EDIT_NONE;
            edit_char_reg   <= (head.kind == ACT_APPEND) ? head.ch : CH_NUL;
            line_length_reg <= head.len;
            last_reg        <= is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign echo_valid  = echo_valid_reg;
    assign echo_byte   = echo_byte_reg;
    assign edit_op     = edit_op_reg;
    assign edit_char   = edit_char_reg;
    assign line_length = line_length_reg;
    assign last        = last_reg;

    // Silent result only for a masked delete, which is a single transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !echo_valid_reg) |-> (last_reg && edit_op_reg == EDIT_DELETE))
        else $error("tief_back: unexpected silent result");

    // Step counter stays within the action being expanded
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (step_reg <= last_step(head.kind)))
        else $error("tief_back: step past end of action");

endmodule

>>> rtl/core/telnet_iac_filter_line_editor.sv
// A byte's first result is registered in the action queue and then in the back end's output register.
// Rates: one byte per cycle in while the queue is not full, one result per cycle out while
//   out_ready is high; a byte gives k results (k = 1..4), and bytes with no result use no output slot.
// The result expander in the back end sets the sustained rate; the action queue
//   lets the front end keep taking bytes while the back end works.
// Reset (rst_n, async, active low) returns command state, CR skip mark and line length to zero.
// ----------------------------------------------------------------------------
// telnet_iac_filter_line_editor
// Telnet receive filter and line editor: strips IAC command sequences and
// subnegotiation, tracks the pending line length and produces echo
// transactions for appends, deletes, commits and abandons.
// ----------------------------------------------------------------------------
module telnet_iac_filter_line_editor
    import tief_pkg::*;
#(
    parameter int LINE_LIMIT  = 256,
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,

    // Received byte channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_of_packet,
    input  logic       password_mode,
    input  logic       discard,

    // Echo / edit result channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic       echo_valid,
    output logic [7:0] echo_byte,
    output logic [2:0] edit_op,
    output logic [7:0] edit_char,
    output logic [8:0] line_length,
    output logic       last
);

    logic    accept;
    logic    push;
    action_t push_data;
    logic    pop;
    action_t head;
    logic    empty;
    logic    full;

    // Every byte is classified in the cycle it is taken; only bytes that
    // cause an edit are queued, so ready depends on queue space alone.
    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    // Front end: IAC stripping, CR/LF skip and line length bookkeeping
    tief_front #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .data_byte      (data_byte),
        .last_of_packet (last_of_packet),
        .password_mode  (password_mode),
        .discard        (discard),
        .push           (push),
        .push_data      (push_data)
    );

    // Decoupling queue of pending edit actions
    tief_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    // Back end: one echo transaction per cycle into the output register while out_ready does not stall it
    tief_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .echo_valid  (echo_valid),
        .echo_byte   (echo_byte),
        .edit_op     (edit_op),
        .edit_char   (edit_char),
        .line_length (line_length),
        .last        (last)
    );

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - telnet_iac_filter_line_editor
// Self-checking bench: drives received bytes over the input valid/ready
// channel, predicts every echo/edit transaction with a line editor model
// kept in the bench and checks the result channel against it.
// ----------------------------------------------------------------------------
module tb;
    import tief_pkg::*;

    localparam int LINE_LIMIT     = 256;
    localparam int RND_ITEMS      = 120;   // non-discarded bytes in the random part
    localparam int FILL_BYTES     = 262;   // runs past the line limit
    localparam int RX_HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES   = 20;    // tail after the last expected result
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
    localparam int MAX_REPORTS    = 60;

    // Telnet parser state of the bench's own editor model
    typedef enum logic [1:0] {
        CS_DATA,
        CS_IAC,
        CS_OPTION,
        CS_SUBNEG
    } cmd_state_t;

    // How a directed row is checked
    typedef enum logic [1:0] {
        ROW_MODEL,   // expectation from the model
        ROW_SILENT,  // typed in: no result
        ROW_ONE      // typed in: exactly one result
    } row_kind_t;

    typedef struct packed {
        logic [7:0] b;
        logic       lop;
        logic       pw;
        logic       disc;
    } rx_t;

    typedef struct packed {
        logic       ev;
        logic [7:0] eb;
        logic [2:0] op;
        logic [7:0] ch;
        logic [8:0] len;
        logic       lst;
    } echo_t;

    typedef struct packed {
        row_kind_t kind;
        rx_t       it;
        echo_t     res;
    } row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       last_of_packet;
    logic       password_mode;
    logic       discard;
    logic       out_valid;
    logic       out_ready;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic [2:0] edit_op;
    logic [7:0] edit_char;
    logic [8:0] line_length;
    logic       last;

    // Editor model state
    cmd_state_t cmd_st;
    logic       cr_mark;
    int         line_len;

    echo_t      echo_q[$];   // echo transactions still to arrive, oldest first
    echo_t      step_q[$];   // echoes caused by the byte just taken
    row_t       dir_tab[$];

    int         err_cnt;
    int         rx_count;
    int         idle_cycles;
    bit         steady;       // no random gaps or stalls on either side while set
    bit         rx_hold_req;  // asks the receiver for one long hold-off

    telnet_iac_filter_line_editor uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .last_of_packet (last_of_packet),
        .password_mode  (password_mode),
        .discard        (discard),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .echo_valid     (echo_valid),
        .echo_byte      (echo_byte),
        .edit_op        (edit_op),
        .edit_char      (edit_char),
        .line_length    (line_length),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Builders
    // ------------------------------------------------------------------
    function automatic rx_t mk_rx(input logic [7:0] b, input logic lop,
                                  input logic pw, input logic disc);
        rx_t r;
        r.b    = b;
        r.lop  = lop;
        r.pw   = pw;
        r.disc = disc;
        return r;
    endfunction

    function automatic echo_t mk_echo(input logic ev, input logic [7:0] eb,
                                      input logic [2:0] op, input logic [7:0] ch,
                                      input int len, input logic lst);
        echo_t e;
        e.ev  = ev;
        e.eb  = eb;
        e.op  = op;
        e.ch  = ch;
        e.len = 9'(len);
        e.lst = lst;
        return e;
    endfunction

    function automatic row_t row_model(input logic [7:0] b, input logic lop,
                                       input logic pw, input logic disc);
        row_t r;
        r.kind = ROW_MODEL;
        r.it   = mk_rx(b, lop, pw, disc);
        r.res  = '0;
        return r;
    endfunction

    function automatic row_t row_silent(input logic [7:0] b, input logic lop,
                                        input logic pw, input logic disc);
        row_t r;
        r.kind = ROW_SILENT;
        r.it   = mk_rx(b, lop, pw, disc);
        r.res  = '0;
        return r;
    endfunction

    function automatic row_t row_one(input logic [7:0] b, input logic lop,
                                     input logic pw, input logic ev,
                                     input logic [7:0] eb, input logic [2:0] op,
                                     input logic [7:0] ch, input int len);
        row_t r;
        r.kind = ROW_ONE;
        r.it   = mk_rx(b, lop, pw, 1'b0);
        r.res  = mk_echo(ev, eb, op, ch, len, 1'b1);
        return r;
    endfunction

    // Random packet boundary and occasional dead-session byte
    function automatic rx_t rnd_rx(input logic [7:0] b, input logic pw);
        return mk_rx(b, $urandom_range(0, 3) == 0, pw, $urandom_range(0, 15) == 0);
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Editor model: telnet command stripping, CR skip and line editing.
    // Leaves the echoes of one byte in step_q.
    // ------------------------------------------------------------------
    task automatic predict_echoes(input rx_t it);
        step_q.delete();
        // a dead session leaves every bit of state alone, CR mark included
        if (it.disc)
            return;
        if (cr_mark)
        begin
            cr_mark = 1'b0;
            if (it.b == CH_LF || it.b == CH_NUL)
                return;
        end
        case (cmd_st)
            CS_IAC:
            begin
                if (it.b == TN_SB)
                    cmd_st = CS_SUBNEG;
                else if (it.b >= TN_WILL && it.b <= TN_DONT)
                    cmd_st = CS_OPTION;
                else
                    cmd_st = CS_DATA;
                return;
            end
            CS_OPTION:
            begin
                cmd_st = CS_DATA;
                return;
            end
            CS_SUBNEG:
            begin
                if (it.b == TN_SE)
                    cmd_st = CS_DATA;
                return;
            end
            default: ;
        endcase
        if (it.b == TN_IAC)
        begin
            cmd_st = CS_IAC;
            return;
        end
        if (it.b == CH_CR || it.b == CH_LF)
        begin
            cr_mark = (it.b == CH_CR) && !it.lop;
            step_q.push_back(mk_echo(1'b1, CH_CR, EDIT_COMMIT, 8'h00, line_len, 1'b0));
            step_q.push_back(mk_echo(1'b1, CH_LF, EDIT_NONE, 8'h00, line_len, 1'b1));
            line_len = 0;
        end
        else if (it.b == CH_DEL || it.b == CH_BS)
        begin
            if (line_len == 0)
                return;
            line_len--;
            if (it.pw)
                step_q.push_back(mk_echo(1'b0, 8'h00, EDIT_DELETE, 8'h00, line_len, 1'b1));
            else
            begin
                step_q.push_back(mk_echo(1'b1, CH_BS, EDIT_DELETE, 8'h00, line_len, 1'b0));
                step_q.push_back(mk_echo(1'b1, CH_SP, EDIT_NONE, 8'h00, line_len, 1'b0));
                step_q.push_back(mk_echo(1'b1, CH_BS, EDIT_NONE, 8'h00, line_len, 1'b1));
            end
        end
        else if (it.b == CH_ETX)
        begin
            line_len = 0;
            step_q.push_back(mk_echo(1'b1, CH_CARET, EDIT_ABANDON, 8'h00, 0, 1'b0));
            step_q.push_back(mk_echo(1'b1, CH_C, EDIT_NONE, 8'h00, 0, 1'b0));
            step_q.push_back(mk_echo(1'b1, CH_CR, EDIT_NONE, 8'h00, 0, 1'b0));
            step_q.push_back(mk_echo(1'b1, CH_LF, EDIT_NONE, 8'h00, 0, 1'b1));
        end
        else if (it.b >= CH_SP && line_len <= LINE_LIMIT)
        begin
            // line holds at most LINE_LIMIT+1 characters
            line_len++;
            step_q.push_back(mk_echo(1'b1, it.pw ? CH_STAR : it.b, EDIT_APPEND, it.b,
                                     line_len, 1'b1));
        end
    endtask

    // ------------------------------------------------------------------
    // Input side: optional gap, then hold the byte until its transaction.
    // The model runs at the accepting edge; use_model picks whether its
    // echoes become the expectation.
    // ------------------------------------------------------------------
    task automatic send_rx(input rx_t it, input bit use_model);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= it.b;
        last_of_packet <= it.lop;
        password_mode  <= it.pw;
        discard        <= it.disc;
        do
            @(posedge clk);
        while (!in_ready);
        predict_echoes(it);
        if (use_model)
            foreach (step_q[i])
                echo_q.push_back(step_q[i]);
        if (!it.disc)
            rx_count++;
    endtask

    // Drop valid and wait for every outstanding echo
    task automatic drain_echoes();
        in_valid <= 1'b0;
        while (echo_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_field(input string fld, input int unsigned want,
                                input int unsigned got);
        if (want != got)
        begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int stall_left;
        int r;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                // long hold-off: lets the block fill up and stall its input
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            else if (stall_left > 0 && !steady)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready  <= 1'b1;
                stall_left = 0;
                if (!steady)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 20)
                        stall_left = $urandom_range(1, 3);
                    else if (r < 24)
                        stall_left = $urandom_range(10, 40);
                end
            end
        end
    end

    // Check each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        echo_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (echo_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected result, echo_byte %02h edit_op %0d",
                             $time, echo_byte, edit_op);
            end
            else
            begin
                want = echo_q.pop_front();
                report_field("echo_valid", want.ev, echo_valid);
                report_field("echo_byte", want.eb, echo_byte);
                report_field("edit_op", want.op, edit_op);
                report_field("edit_char", want.ch, edit_char);
                report_field("line_length", want.len, line_length);
                report_field("last", want.lst, last);
            end
        end
    end

    // Watchdog: any transaction on either channel restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("telnet_iac_filter_line_editor test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int   kind;
        int   n;
        logic pw;
        logic [7:0] b;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        data_byte      = 8'h00;
        last_of_packet = 1'b0;
        password_mode  = 1'b0;
        discard        = 1'b0;
        cmd_st         = CS_DATA;
        cr_mark        = 1'b0;
        line_len       = 0;
        err_cnt        = 0;
        rx_count       = 0;
        idle_cycles    = 0;
        steady         = 1'b0;
        rx_hold_req    = 1'b0;

        // Directed rows, typed where the outcome is plain
        dir_tab.push_back(row_one(8'h41, 1'b0, 1'b0, 1'b1, 8'h41, EDIT_APPEND, 8'h41, 1));
        // option negotiation: IAC DONT <opt>
        dir_tab.push_back(row_silent(TN_IAC, 1'b0, 1'b0, 1'b0));
        dir_tab.push_back(row_silent(TN_DONT, 1'b0, 1'b0, 1'b0));
        dir_tab.push_back(row_silent(8'h01, 1'b0, 1'b0, 1'b0));
        // subnegotiation, with an IAC byte inside it
        dir_tab.push_back(row_silent(TN_IAC, 1'b0, 1'b0, 1'b0));
        dir_tab.push_back(row_silent(TN_SB, 1'b0, 1'b0, 1'b0));
        dir_tab.push_back(row_silent(TN_IAC, 1'b0, 1'b0, 1'b0));
        dir_tab.push_back(row_silent(TN_SE, 1'b1, 1'b0, 1'b0));
        // plain two-byte command
        dir_tab.push_back(row_silent(TN_IAC, 1'b0, 1'b0, 1'b0));
        dir_tab.push_back(row_silent(8'hf1, 1'b0, 1'b0, 1'b0));
        dir_tab.push_back(row_model(CH_BS, 1'b0, 1'b0, 1'b0));
        // delete on an empty line
        dir_tab.push_back(row_silent(CH_DEL, 1'b0, 1'b0, 1'b0));
        dir_tab.push_back(row_one(8'h62, 1'b0, 1'b1, 1'b1, CH_STAR, EDIT_APPEND, 8'h62, 1));
        // masked delete: one result, nothing echoed
        dir_tab.push_back(row_one(CH_DEL, 1'b0, 1'b1, 1'b0, 8'h00, EDIT_DELETE, 8'h00, 0));
        dir_tab.push_back(row_model(8'h7e, 1'b0, 1'b0, 1'b0));
        dir_tab.push_back(row_model(CH_ETX, 1'b0, 1'b0, 1'b0));
        // CR mid-packet swallows the LF after it
        dir_tab.push_back(row_model(CH_CR, 1'b0, 1'b0, 1'b0));
        dir_tab.push_back(row_silent(CH_LF, 1'b0, 1'b0, 1'b0));
        // discarded byte keeps the mark, so the NUL is still swallowed
        dir_tab.push_back(row_model(CH_CR, 1'b0, 1'b0, 1'b0));
        dir_tab.push_back(row_silent(8'h41, 1'b1, 1'b1, 1'b1));
        dir_tab.push_back(row_silent(CH_NUL, 1'b0, 1'b0, 1'b0));
        // CR at the end of a packet: next LF commits again
        dir_tab.push_back(row_model(CH_CR, 1'b1, 1'b0, 1'b0));
        dir_tab.push_back(row_model(CH_LF, 1'b0, 1'b0, 1'b0));
        dir_tab.push_back(row_silent(8'h01, 1'b0, 1'b0, 1'b0));
        dir_tab.push_back(row_one(8'hfe, 1'b1, 1'b1, 1'b1, CH_STAR, EDIT_APPEND, 8'hfe, 1));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (dir_tab[i])
        begin
            send_rx(dir_tab[i].it, dir_tab[i].kind == ROW_MODEL);
            if (dir_tab[i].kind == ROW_ONE)
                echo_q.push_back(dir_tab[i].res);
        end

        // Sender pauses until every echo is back
        drain_echoes();

        // Long line past the limit under a long receiver hold-off:
        // the block fills up and holds off its input
        rx_hold_req = 1'b1;
        steady      = 1'b1;
        for (int i = 0; i < FILL_BYTES; i++)
            send_rx(mk_rx(8'($urandom_range(8'h21, 8'h7e)), 1'b0,
                          1'($urandom_range(0, 1)), 1'b0), 1'b1);
        steady = 1'b0;
        send_rx(mk_rx(CH_DEL, 1'b0, 1'b0, 1'b0), 1'b1);
        send_rx(mk_rx(CH_BS, 1'b0, 1'b1, 1'b0), 1'b1);
        send_rx(mk_rx(CH_CR, 1'b1, 1'b0, 1'b0), 1'b1);
        drain_echoes();

        // Random part: mostly well-formed editing and telnet sequences
        rx_count = 0;
        while (rx_count < RND_ITEMS)
        begin
            pw     = ($urandom_range(0, 3) == 0);
            steady = ($urandom_range(0, 3) == 0);
            kind   = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3:
                begin
                    n = $urandom_range(1, 8);
                    repeat (n)
                        send_rx(rnd_rx(8'($urandom_range(8'h20, 8'hfe)), pw), 1'b1);
                end
                4:
                begin
                    n = $urandom_range(1, 3);
                    repeat (n)
                        send_rx(rnd_rx($urandom_range(0, 1) ? CH_DEL : CH_BS, pw), 1'b1);
                end
                5:
                begin
                    send_rx(rnd_rx(TN_IAC, pw), 1'b1);
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            send_rx(rnd_rx(8'($urandom_range(TN_WILL, TN_DONT)), pw), 1'b1);
                            send_rx(rnd_rx(8'($urandom), pw), 1'b1);
                        end
                        1:
                        begin
                            b = 8'($urandom);
                            if (b >= TN_SB && b <= TN_DONT)
                                b = TN_IAC;
                            send_rx(rnd_rx(b, pw), 1'b1);
                        end
                        default:
                        begin
                            send_rx(rnd_rx(TN_SB, pw), 1'b1);
                            n = $urandom_range(0, 4);
                            repeat (n)
                                send_rx(rnd_rx(8'($urandom), pw), 1'b1);
                            send_rx(rnd_rx(TN_SE, pw), 1'b1);
                        end
                    endcase
                end
                6, 7:
                begin
                    send_rx(rnd_rx($urandom_range(0, 3) == 0 ? CH_LF : CH_CR, pw), 1'b1);
                    case ($urandom_range(0, 3))
                        0: send_rx(rnd_rx(CH_LF, pw), 1'b1);
                        1: send_rx(rnd_rx(CH_NUL, pw), 1'b1);
                        2: send_rx(rnd_rx(8'($urandom), pw), 1'b1);
                        default: ;
                    endcase
                end
                8:
                    send_rx(rnd_rx(CH_ETX, pw), 1'b1);
                default:
                begin
                    // noise: any byte, any flags
                    n = $urandom_range(1, 4);
                    repeat (n)
                        send_rx(mk_rx(8'($urandom), 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1)),
                                      $urandom_range(0, 3) == 0), 1'b1);
                end
            endcase
        end
        steady = 1'b0;

        // Wind-down: all echoes back, then a short tail to catch extras
        drain_echoes();
        steady = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0)
            $display("telnet_iac_filter_line_editor test passed");
        else
            $display("telnet_iac_filter_line_editor test failed");
        $finish;
    end

endmodule
